### design/frwm_pkg.sv
// Shared types, widths and constants of the frame rate window monitor.
package frwm_pkg;

	localparam int RING_DEPTH = 256;
	localparam int TIME_BITS  = 24;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int HELD_W     = $clog2(RING_DEPTH + 1);
	localparam int CFG_W      = 9;
	localparam int CMP_W      = (HELD_W > CFG_W) ? HELD_W : CFG_W;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 64;
	localparam int FPS_W      = 28;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);
	localparam logic [SUM_W-1:0] FPS_SCALE    = SUM_W'(256000000);

	typedef struct packed {
		logic [TIME_BITS-1:0] frame_time_us;
		logic [TIME_BITS-1:0] work_time_us;
		logic [TIME_BITS-1:0] wait_time_us;
	} frame_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] avg_frame_time_us;
		logic [FPS_W-1:0]     avg_fps_q8;
		logic [TIME_BITS-1:0] last_work_time_us;
		logic [TIME_BITS-1:0] last_wait_time_us;
		logic [CNT_W-1:0]     frame_total;
	} result_t;

	typedef struct packed {
		logic latch_in;
		logic cfg_we;
		logic trim_rd;
		logic trim_sub;
		logic push;
		logic div_start;
		logic div_sel_fps;
		logic avg_load;
		logic fps_load;
		logic fps_zero;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic over_cfg;
		logic over_step;
		logic div_done;
		logic avg_zero;
	} status_t;

endpackage

### design/frame_rate_window_monitor_unit.sv
// Top level of the frame rate window monitor: windowed average frame time and rate.
//
//  channel   direction  handshake                payload
//  frame     in         frame_valid/frame_stall  frame  (frame_t)
//  result    out        result_valid/result_stall result (result_t)
//  cfg       in         cfg_valid/cfg_ready      cfg_data (window length, 9 bits)
//
// A frame goes from transfer to result_valid through the trim check, a drop of the oldest
// entry when needed, push, then the shared restoring divider twice, each run including its
// start state (average, then rate). A zero average skips the rate division. A new frame is
// taken only once the controller is idle again after the result is loaded.
// A window write drops entries above the new length, one ring read each.
// The result register holds while result_stall is high; the next frame is taken
// meanwhile and its result waits in the controller until the register frees.
// arst_n clears control state, window length returns to 64; the ring is not cleared.
module frame_rate_window_monitor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       frame_valid,
	output logic                       frame_stall,
	input  frwm_pkg::frame_t           frame,
	output logic                       result_valid,
	input  logic                       result_stall,
	output frwm_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [frwm_pkg::CFG_W-1:0] cfg_data
);

	frwm_pkg::cmd_t    cmd;
	frwm_pkg::status_t status;

	frwm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.status       (status),
		.cmd          (cmd)
	);

	frwm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.frame    (frame),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

### design/frwm_div.sv
// Restoring divider, one quotient bit per cycle.
module frwm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [frwm_pkg::SUM_W-1:0]     dividend,
	input  logic [frwm_pkg::TIME_BITS-1:0] divisor,
	output logic [frwm_pkg::SUM_W-1:0]     quotient,
	output logic                           done
);

	logic                               busy_q;
	logic                               done_q;
	logic [frwm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [frwm_pkg::SUM_W-1:0]         quo_q;
	logic [frwm_pkg::TIME_BITS-1:0]     rem_q;
	logic [frwm_pkg::TIME_BITS-1:0]     dsr_q;
	logic [frwm_pkg::TIME_BITS:0]       rem_sh;
	logic                               fits;

	assign rem_sh = {rem_q, quo_q[frwm_pkg::SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == frwm_pkg::DIV_CNT_W'(frwm_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[frwm_pkg::SUM_W-2:0], fits};
			if (fits) begin
				rem_q <= frwm_pkg::TIME_BITS'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[frwm_pkg::TIME_BITS-1:0];
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### design/frwm_datapath.sv
// Datapath: frame ring, running sum, counters, divider and result register.
module frwm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frwm_pkg::cmd_t             cmd,
	output frwm_pkg::status_t          status,
	input  frwm_pkg::frame_t           frame,
	input  logic [frwm_pkg::CFG_W-1:0] cfg_data,
	output frwm_pkg::result_t          result
);

	logic [frwm_pkg::TIME_BITS-1:0] ring_q [frwm_pkg::RING_DEPTH];
	logic [frwm_pkg::TIME_BITS-1:0] rd_data_q;
	frwm_pkg::frame_t               frame_q;
	logic [frwm_pkg::CFG_W-1:0]     window_q;
	logic [frwm_pkg::ADDR_W-1:0]    slot_q;
	logic [frwm_pkg::HELD_W-1:0]    held_q;
	logic [frwm_pkg::SUM_W-1:0]     sum_q;
	logic [frwm_pkg::CNT_W-1:0]     count_q;
	logic [frwm_pkg::TIME_BITS-1:0] avg_q;
	logic [frwm_pkg::FPS_W-1:0]     fps_q;
	frwm_pkg::result_t              result_q;

	logic [frwm_pkg::CMP_W-1:0]     win_ext;
	logic [frwm_pkg::CMP_W-1:0]     weff;
	logic [frwm_pkg::CMP_W-1:0]     held_ext;
	logic [frwm_pkg::HELD_W:0]      old_sum;
	logic [frwm_pkg::HELD_W:0]      old_pos;
	logic [frwm_pkg::ADDR_W-1:0]    old_addr;
	logic [frwm_pkg::SUM_W-1:0]     div_dividend;
	logic [frwm_pkg::TIME_BITS-1:0] div_divisor;
	logic [frwm_pkg::SUM_W-1:0]     div_quot;
	logic                           div_done;

	// effective window: zero acts as one, saturates at the ring depth
	assign win_ext  = frwm_pkg::CMP_W'(window_q);
	assign held_ext = frwm_pkg::CMP_W'(held_q);

	always_comb begin
		if (win_ext == '0) begin
			weff = frwm_pkg::CMP_W'(1);
		end else if (win_ext > frwm_pkg::CMP_W'(frwm_pkg::RING_DEPTH)) begin
			weff = frwm_pkg::CMP_W'(frwm_pkg::RING_DEPTH);
		end else begin
			weff = win_ext;
		end
	end

	// oldest slot: (slot + depth - held) mod depth
	assign old_sum = (frwm_pkg::HELD_W+1)'(slot_q) + (frwm_pkg::HELD_W+1)'(frwm_pkg::RING_DEPTH)
		- (frwm_pkg::HELD_W+1)'(held_q);

	always_comb begin
		if (old_sum >= (frwm_pkg::HELD_W+1)'(frwm_pkg::RING_DEPTH)) begin
			old_pos = old_sum - (frwm_pkg::HELD_W+1)'(frwm_pkg::RING_DEPTH);
		end else begin
			old_pos = old_sum;
		end
	end

	assign old_addr = old_pos[frwm_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[slot_q] <= frame_q.frame_time_us;
		end
		if (cmd.trim_rd) begin
			rd_data_q <= ring_q[old_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			frame_q <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= frwm_pkg::WINDOW_RESET;
			slot_q   <= '0;
			held_q   <= '0;
			sum_q    <= '0;
			count_q  <= '0;
		end else begin
			if (cmd.cfg_we) begin
				window_q <= cfg_data;
			end
			if (cmd.trim_sub) begin
				sum_q  <= sum_q - frwm_pkg::SUM_W'(rd_data_q);
				held_q <= held_q - 1'b1;
			end else if (cmd.push) begin
				sum_q   <= sum_q + frwm_pkg::SUM_W'(frame_q.frame_time_us);
				held_q  <= held_q + 1'b1;
				count_q <= count_q + 1'b1;
				if (slot_q == frwm_pkg::ADDR_W'(frwm_pkg::RING_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	assign div_dividend = cmd.div_sel_fps ? frwm_pkg::FPS_SCALE : sum_q;
	assign div_divisor  = cmd.div_sel_fps ? avg_q : frwm_pkg::TIME_BITS'(held_q);

	frwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.avg_load) begin
			avg_q <= div_quot[frwm_pkg::TIME_BITS-1:0];
		end
		if (cmd.fps_zero) begin
			fps_q <= '0;
		end else if (cmd.fps_load) begin
			fps_q <= div_quot[frwm_pkg::FPS_W-1:0];
		end
		if (cmd.out_load) begin
			result_q.avg_frame_time_us <= avg_q;
			result_q.avg_fps_q8        <= fps_q;
			result_q.last_work_time_us <= frame_q.work_time_us;
			result_q.last_wait_time_us <= frame_q.wait_time_us;
			result_q.frame_total       <= count_q;
		end
	end

	assign status.over_cfg  = held_ext > weff;
	assign status.over_step = held_ext >= weff;
	assign status.div_done  = div_done;
	assign status.avg_zero  = avg_q == '0;
	assign result           = result_q;

endmodule

### design/frwm_ctrl.sv
// Controller: sequences trimming, push, one or both divisions and the result transfer.
module frwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  frwm_pkg::status_t status,
	output frwm_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_TRIM_CHK = 4'd1;
	localparam logic [3:0] S_TRIM_SUB = 4'd2;
	localparam logic [3:0] S_PUSH     = 4'd3;
	localparam logic [3:0] S_AVG_GO   = 4'd4;
	localparam logic [3:0] S_AVG_WAIT = 4'd5;
	localparam logic [3:0] S_FPS_CHK  = 4'd6;
	localparam logic [3:0] S_FPS_WAIT = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       step_q;
	logic       step_d;
	logic       out_valid_q;
	logic       cfg_xfer;
	logic       in_xfer;
	logic       over;

	assign cfg_ready   = state_q == S_IDLE;
	assign frame_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_xfer    = cfg_valid && cfg_ready;
	assign in_xfer     = frame_valid && !frame_stall;
	assign over        = step_q ? status.over_step : status.over_cfg;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_xfer) begin
					cmd.cfg_we = 1'b1;
					step_d     = 1'b0;
					state_d    = S_TRIM_CHK;
				end else if (in_xfer) begin
					cmd.latch_in = 1'b1;
					step_d       = 1'b1;
					state_d      = S_TRIM_CHK;
				end
			end
			S_TRIM_CHK: begin
				if (over) begin
					cmd.trim_rd = 1'b1;
					state_d     = S_TRIM_SUB;
				end else if (step_q) begin
					state_d = S_PUSH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TRIM_SUB: begin
				cmd.trim_sub = 1'b1;
				state_d      = S_TRIM_CHK;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_AVG_GO;
			end
			S_AVG_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_AVG_WAIT;
			end
			S_AVG_WAIT: begin
				if (status.div_done) begin
					cmd.avg_load = 1'b1;
					state_d      = S_FPS_CHK;
				end
			end
			S_FPS_CHK: begin
				if (status.avg_zero) begin
					cmd.fps_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.div_start   = 1'b1;
					cmd.div_sel_fps = 1'b1;
					state_d         = S_FPS_WAIT;
				end
			end
			S_FPS_WAIT: begin
				if (status.div_done) begin
					cmd.fps_load = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

### sim/frame_rate_window_monitor_unit_tb.sv
// Testbench for frame_rate_window_monitor_unit: frame records checked against a predictor.
`timescale 1ns / 1ps

module frame_rate_window_monitor_unit_tb;

	localparam int IDLE_LIMIT = 20000;

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       frame_valid  = 1'b0;
	logic                       frame_stall;
	frwm_pkg::frame_t           frame        = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	frwm_pkg::result_t          result;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [frwm_pkg::CFG_W-1:0] cfg_data     = '0;

	frame_rate_window_monitor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [frwm_pkg::TIME_BITS-1:0] ring_times [frwm_pkg::RING_DEPTH];
	logic [frwm_pkg::ADDR_W-1:0]    ring_wr     = '0;
	int unsigned                    held        = 0;
	logic [frwm_pkg::SUM_W-1:0]     time_sum    = '0;
	logic [frwm_pkg::CNT_W-1:0]     frames_seen = '0;
	logic [frwm_pkg::CFG_W-1:0]     win_len     = frwm_pkg::WINDOW_RESET;

	frwm_pkg::frame_t  pending [$];
	frwm_pkg::result_t results_due [$];
	frwm_pkg::result_t want_result;

	int frames_queued = 0;
	int frames_taken  = 0;
	int fail_count    = 0;
	int idle_cycles   = 0;
	int cycles        = 0;
	int burst_left    = 1;
	int gap_left      = 0;
	int stall_run     = 0;
	logic frame_sent  = 1'b0;

	function automatic int unsigned window_limit();
		int unsigned w;
		w = win_len;
		if (w == 0)
			w = 1;
		if (w > frwm_pkg::RING_DEPTH)
			w = frwm_pkg::RING_DEPTH;
		return w;
	endfunction

	function automatic void drop_oldest_frame();
		logic [frwm_pkg::ADDR_W-1:0] idx;
		if (held == 0)
			return;
		idx = ring_wr - frwm_pkg::ADDR_W'(held);
		time_sum = time_sum - frwm_pkg::SUM_W'(ring_times[idx]);
		held = held - 1;
	endfunction

	function automatic void apply_window(logic [frwm_pkg::CFG_W-1:0] v);
		win_len = v;
		while (held > window_limit())
			drop_oldest_frame();
	endfunction

	function automatic frwm_pkg::result_t predict_frame(frwm_pkg::frame_t f);
		frwm_pkg::result_t              r;
		logic [frwm_pkg::TIME_BITS-1:0] avg;
		while (held >= window_limit())
			drop_oldest_frame();
		ring_times[ring_wr] = f.frame_time_us;
		ring_wr = ring_wr + 1'b1;
		time_sum = time_sum + frwm_pkg::SUM_W'(f.frame_time_us);
		held = held + 1;
		frames_seen = frames_seen + 1'b1;
		avg = frwm_pkg::TIME_BITS'(time_sum / frwm_pkg::SUM_W'(held));
		r.avg_frame_time_us = avg;
		r.avg_fps_q8 = (avg == '0) ? '0 :
			frwm_pkg::FPS_W'(frwm_pkg::FPS_SCALE / frwm_pkg::SUM_W'(avg));
		r.last_work_time_us = f.work_time_us;
		r.last_wait_time_us = f.wait_time_us;
		r.frame_total = frames_seen;
		return r;
	endfunction

	function automatic frwm_pkg::frame_t rand_frame();
		frwm_pkg::frame_t f;
		case ($urandom_range(0, 7))
			0: f.frame_time_us = '0;
			1: f.frame_time_us = '1;
			2, 3: f.frame_time_us = frwm_pkg::TIME_BITS'($urandom_range(1, 40000));
			4: f.frame_time_us = frwm_pkg::TIME_BITS'($urandom_range(1, 300));
			default: f.frame_time_us = frwm_pkg::TIME_BITS'($urandom());
		endcase
		f.work_time_us = frwm_pkg::TIME_BITS'($urandom());
		f.wait_time_us = frwm_pkg::TIME_BITS'($urandom());
		return f;
	endfunction

	function automatic int next_gap();
		if ((cycles % 1000) < 250)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 90);
		return 0;
	endfunction

	task automatic compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic queue_frame(logic [frwm_pkg::TIME_BITS-1:0] t,
			logic [frwm_pkg::TIME_BITS-1:0] busy, logic [frwm_pkg::TIME_BITS-1:0] idle);
		frwm_pkg::frame_t f;
		f.frame_time_us = t;
		f.work_time_us  = busy;
		f.wait_time_us  = idle;
		pending.insert(pending.size(), f);
		frames_queued++;
	endtask

	task automatic queue_random(int n);
		repeat (n) begin
			pending.insert(pending.size(), rand_frame());
			frames_queued++;
		end
	endtask

	task automatic settle();
		while (frames_taken != frames_queued || results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_window(logic [frwm_pkg::CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [frwm_pkg::CFG_W-1:0] pick_window();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return frwm_pkg::CFG_W'($urandom_range(1, 16));
			3: return frwm_pkg::CFG_W'($urandom_range(1, frwm_pkg::RING_DEPTH));
			4: return frwm_pkg::CFG_W'($urandom());
			default: return frwm_pkg::CFG_W'(frwm_pkg::RING_DEPTH);
		endcase
	endfunction

	// frame sender: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!frame_valid || frame_sent)) begin
			if (gap_left != 0) begin
				frame_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() != 0) begin
				frame       <= pending[0];
				pending.delete(0);
				frame_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= next_gap();
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// result receiver stall pattern
	always @(negedge clk) begin
		cycles <= cycles + 1;
		case ((cycles / 300) % 3)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run == 0) begin
					stall_run    <= $urandom_range(1, 40);
					result_stall <= !result_stall;
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	// transfer monitor, prediction, checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			frame_sent <= frame_valid && !frame_stall;
			if (frame_valid && !frame_stall) begin
				results_due.insert(results_due.size(), predict_frame(frame));
				frames_taken <= frames_taken + 1;
			end
			if (cfg_valid && cfg_ready)
				apply_window(cfg_data);
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					$error("result with no frame outstanding: %p", result);
					fail_count++;
				end else begin
					want_result = results_due[0];
					results_due.delete(0);
					compare_field("avg_frame_time_us", 64'(want_result.avg_frame_time_us),
						64'(result.avg_frame_time_us));
					compare_field("avg_fps_q8", 64'(want_result.avg_fps_q8),
						64'(result.avg_fps_q8));
					compare_field("last_work_time_us", 64'(want_result.last_work_time_us),
						64'(result.last_work_time_us));
					compare_field("last_wait_time_us", 64'(want_result.last_wait_time_us),
						64'(result.last_wait_time_us));
					compare_field("frame_total", want_result.frame_total, result.frame_total);
				end
			end
			if ((frame_valid && !frame_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default window, zero average and extremes
		queue_frame('0, '0, '0);
		queue_frame('1, '1, '1);
		queue_frame(24'd1, 24'hAAAAAA, 24'h555555);
		queue_frame(24'd256, 24'h555555, 24'hAAAAAA);
		settle();

		write_window(frwm_pkg::CFG_W'(1));
		queue_frame('0, 24'h000001, 24'h800000);
		queue_frame(24'd1, 24'h800000, 24'h000001);
		queue_frame('1, '0, '1);
		settle();

		// zero window behaves as one
		write_window('0);
		queue_frame(24'd5, '1, '0);
		queue_frame(24'd1000, 24'h123456, 24'h654321);
		settle();

		// load six frames then lower the window so the oldest entries are trimmed
		write_window(frwm_pkg::CFG_W'(8));
		queue_frame(24'd16667, 24'd10000, 24'd6667);
		queue_frame(24'd33333, 24'd20000, 24'd13333);
		queue_frame(24'd7, 24'd3, 24'd4);
		queue_frame('1, '1, '0);
		queue_frame(24'd2, 24'd1, 24'd1);
		queue_frame(24'd3, 24'd1, 24'd2);
		settle();
		write_window(frwm_pkg::CFG_W'(2));
		queue_frame(24'd4, 24'd2, 24'd2);
		queue_frame('0, '0, '0);
		settle();

		// window above ring depth saturates
		write_window('1);
		queue_frame(24'd100, 24'd50, 24'd50);
		queue_frame('1, '1, '1);
		queue_frame(24'd1, '0, '0);
		settle();

		// full ring with wrap of the write slot
		write_window(frwm_pkg::CFG_W'(frwm_pkg::RING_DEPTH));
		queue_random(270);
		settle();
		write_window(frwm_pkg::CFG_W'(3));
		queue_random(10);
		settle();

		repeat (8) begin
			write_window(pick_window());
			queue_random($urandom_range(15, 25));
			settle();
		end

		settle();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
